@@ rtl/vlid_pkg.sv @@
package vlid_pkg;

	// Bit positions inside the opcode byte and the operand descriptor byte
	localparam int OPCODE_SHIFT = 3;
	localparam int SIZE_BIT_POS = 2;
	localparam int MODE_SHIFT   = 5;
	localparam int REG_SHIFT    = 1;

	// Opcodes from this value up have no table entry
	localparam logic [4:0] TABLE_LEN = 5'd26;

	// Queue between classifier and sequencer
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Addressing modes
	localparam logic [2:0] MODE_IMMED    = 3'd0;
	localparam logic [2:0] MODE_REGDIR   = 3'd1;
	localparam logic [2:0] MODE_REGIND   = 3'd2;
	localparam logic [2:0] MODE_REGIND8  = 3'd3;
	localparam logic [2:0] MODE_REGIND16 = 3'd4;
	localparam logic [2:0] MODE_MEMORY   = 3'd5;

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_MODE = 2'd1;
	localparam logic [1:0] ERR_BAD_OP   = 2'd2;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       restart;
	} code_t;

	typedef struct packed {
		logic [4:0]  opcode;
		logic        byte_ops;
		logic [2:0]  length;
		logic [1:0]  op_count;
		logic [2:0]  mode_a;
		logic [15:0] value_a;
		logic [15:0] extra_a;
		logic [2:0]  mode_b;
		logic [15:0] value_b;
		logic [15:0] extra_b;
		logic [1:0]  error;
	} instr_t;

	// Classified byte as it sits in the queue
	typedef struct packed {
		logic [7:0] code_byte;
		logic       restart;
		logic [4:0] opcode;
		logic       byte_sz;
		logic       bad_op;
		logic [1:0] n_ops;
		logic [2:0] mode;
		logic [3:0] regnum;
	} qent_t;

	// One decoded operand
	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] value;
		logic [15:0] extra;
	} oper_t;

	// Operand count per opcode
	function automatic logic [1:0] op_count_f(input logic [4:0] opc);
		logic [1:0] n;
		case (opc)
			5'd0, 5'd1, 5'd24, 5'd25:                 n = 2'd0;
			5'd3, 5'd10, 5'd17, 5'd18, 5'd19, 5'd20,
			5'd21, 5'd22, 5'd23:                      n = 2'd1;
			5'd2, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
			5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16: n = 2'd2;
			default:                                  n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/vlid_front.sv @@
module vlid_front import vlid_pkg::*; (
	input  logic  code_valid,
	output logic  code_ready,
	input  code_t code_item,
	input  logic  q_full,
	output logic  q_push,
	output qent_t q_wdata
);

	logic [7:0] b;

	assign b          = code_item.code_byte;
	assign code_ready = !q_full;
	assign q_push     = code_valid && !q_full;

	// Split the byte both ways; the sequencer picks the view its phase needs
	always_comb begin
		q_wdata.code_byte = b;
		q_wdata.restart   = code_item.restart;
		q_wdata.opcode    = b[OPCODE_SHIFT +: 5];
		q_wdata.byte_sz   = !b[SIZE_BIT_POS];
		q_wdata.bad_op    = (b[OPCODE_SHIFT +: 5] >= TABLE_LEN);
		q_wdata.n_ops     = op_count_f(b[OPCODE_SHIFT +: 5]);
		q_wdata.mode      = b[MODE_SHIFT +: 3];
		q_wdata.regnum    = b[REG_SHIFT +: 4];
	end

endmodule

@@ rtl/vlid_queue.sv @@
module vlid_queue import vlid_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output qent_t rdata
);

	qent_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

@@ rtl/vlid_back.sv @@
module vlid_back import vlid_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  qent_t  q_data,
	output logic   q_pop,
	output logic   instr_valid,
	input  logic   instr_ready,
	output instr_t instr_item
);

	localparam logic [1:0] PH_OPCODE = 2'd0;
	localparam logic [1:0] PH_DESC   = 2'd1;
	localparam logic [1:0] PH_EXT1   = 2'd2;
	localparam logic [1:0] PH_EXT2   = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic [4:0] opcode_q, opcode_d;
	logic       size_q, size_d;
	logic [2:0] bcount_q, bcount_d;
	logic       opidx_q, opidx_d;
	logic [1:0] need_q, need_d;
	logic [2:0] mode_q, mode_d;
	logic [3:0] regnum_q, regnum_d;
	logic [7:0] low_q, low_d;
	oper_t      first_q, first_d;

	logic       emit;
	logic [1:0] emit_count;
	logic [1:0] emit_err;
	oper_t      oper_b;
	logic       fin;
	oper_t      fin_op;
	logic [7:0] b;
	instr_t     res;
	logic       out_valid_q;
	instr_t     out_q;

	assign b     = q_data.code_byte;
	assign q_pop = q_valid && (!out_valid_q || instr_ready);

	// Step the decode sequence for the popped byte
	always_comb begin
		phase_d    = phase_q;
		opcode_d   = opcode_q;
		size_d     = size_q;
		bcount_d   = bcount_q;
		opidx_d    = opidx_q;
		need_d     = need_q;
		mode_d     = mode_q;
		regnum_d   = regnum_q;
		low_d      = low_q;
		first_d    = first_q;
		emit       = 1'b0;
		emit_count = 2'd0;
		emit_err   = ERR_NONE;
		oper_b     = '0;
		fin        = 1'b0;
		fin_op     = '0;
		if (q_pop) begin
			if (q_data.restart || phase_q == PH_OPCODE) begin
				opcode_d = q_data.opcode;
				size_d   = q_data.byte_sz;
				bcount_d = 3'd1;
				opidx_d  = 1'b0;
				first_d  = '0;
				if (q_data.bad_op) begin
					need_d   = 2'd0;
					emit     = 1'b1;
					emit_err = ERR_BAD_OP;
				end else begin
					need_d = q_data.n_ops;
					if (q_data.n_ops == 2'd0) begin
						emit = 1'b1;
					end else begin
						phase_d = PH_DESC;
					end
				end
			end else begin
				bcount_d = bcount_q + 3'd1;
				case (phase_q)
					PH_DESC: begin
						mode_d   = q_data.mode;
						regnum_d = q_data.regnum;
						case (q_data.mode)
							MODE_IMMED, MODE_REGIND8, MODE_REGIND16, MODE_MEMORY: begin
								phase_d = PH_EXT1;
							end
							MODE_REGDIR: begin
								fin    = 1'b1;
								fin_op = '{MODE_REGDIR, {12'd0, q_data.regnum}, {15'd0, b[0]}};
							end
							MODE_REGIND: begin
								fin    = 1'b1;
								fin_op = '{MODE_REGIND, {12'd0, q_data.regnum}, 16'd0};
							end
							default: begin
								emit       = 1'b1;
								emit_count = {1'b0, opidx_q};
								emit_err   = ERR_BAD_MODE;
							end
						endcase
					end
					PH_EXT1: begin
						if (mode_q == MODE_REGIND8) begin
							fin    = 1'b1;
							fin_op = '{MODE_REGIND8, {12'd0, regnum_q}, {8'd0, b}};
						end else if (mode_q == MODE_IMMED && size_q) begin
							fin    = 1'b1;
							fin_op = '{MODE_IMMED, {8'd0, b}, 16'd0};
						end else begin
							low_d   = b;
							phase_d = PH_EXT2;
						end
					end
					default: begin
						fin = 1'b1;
						if (mode_q == MODE_REGIND16) begin
							fin_op = '{MODE_REGIND16, {12'd0, regnum_q}, {b, low_q}};
						end else if (mode_q == MODE_MEMORY) begin
							fin_op = '{MODE_MEMORY, {b, low_q}, 16'd0};
						end else begin
							fin_op = '{MODE_IMMED, {b, low_q}, 16'd0};
						end
					end
				endcase
			end
			// Close the operand: hold it as the first, or finish the instruction
			if (fin) begin
				if (!opidx_q) begin
					first_d = fin_op;
					if (need_q >= 2'd2) begin
						opidx_d = 1'b1;
						phase_d = PH_DESC;
					end else begin
						emit       = 1'b1;
						emit_count = 2'd1;
					end
				end else begin
					emit       = 1'b1;
					emit_count = 2'd2;
					oper_b     = fin_op;
				end
			end
			if (emit) begin
				phase_d = PH_OPCODE;
			end
		end
	end

	// Assemble the result transaction
	always_comb begin
		res.opcode   = opcode_d;
		res.byte_ops = size_d;
		res.length   = bcount_d;
		res.op_count = emit_count;
		res.mode_a   = (emit_count != 2'd0) ? first_d.mode : 3'd0;
		res.value_a  = (emit_count != 2'd0) ? first_d.value : 16'd0;
		res.extra_a  = (emit_count != 2'd0) ? first_d.extra : 16'd0;
		res.mode_b   = oper_b.mode;
		res.value_b  = oper_b.value;
		res.extra_b  = oper_b.extra;
		res.error    = emit_err;
	end

	// Hold decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			opcode_q <= '0;
			size_q   <= 1'b0;
			bcount_q <= '0;
			opidx_q  <= 1'b0;
			need_q   <= '0;
			mode_q   <= '0;
			regnum_q <= '0;
			low_q    <= '0;
			first_q  <= '0;
		end else begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			size_q   <= size_d;
			bcount_q <= bcount_d;
			opidx_q  <= opidx_d;
			need_q   <= need_d;
			mode_q   <= mode_d;
			regnum_q <= regnum_d;
			low_q    <= low_d;
			first_q  <= first_d;
		end
	end

	// Output register: load on a finished instruction, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (instr_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_q <= res;
		end
	end

	assign instr_valid = out_valid_q;
	assign instr_item  = out_q;

endmodule

@@ rtl/variable_length_instruction_decoder.sv @@
// Variable-length instruction decoder. Instruction bytes enter on the code
// channel one per transaction; code_item.restart marks a byte to be taken as
// an opcode byte, dropping any partly decoded instruction without a result.
// A decoded instruction leaves on the instr channel when its last byte (or a
// bad opcode or bad addressing mode) has been seen. One byte is taken every
// cycle while the instr side keeps up: a classifier writes each byte into a
// four-entry queue, and a sequencer pops one entry per cycle, while the
// single output register is free or being taken, and registers each result
// there once its last byte has passed the queue. When the output register
// stalls, the queue fills up to four bytes before code_ready drops.
module variable_length_instruction_decoder import vlid_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   code_valid,
	output logic   code_ready,
	input  code_t  code_item,
	output logic   instr_valid,
	input  logic   instr_ready,
	output instr_t instr_item
);

	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_valid;
	qent_t q_wdata;
	qent_t q_rdata;

	vlid_front u_front (
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code_item  (code_item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	vlid_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rdata     (q_rdata)
	);

	vlid_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.instr_valid (instr_valid),
		.instr_ready (instr_ready),
		.instr_item  (instr_item)
	);

endmodule

@@ tb/sv/vlid_decode_checker.sv @@
`timescale 1ns / 1ps
module vlid_decode_checker import vlid_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   code_valid,
	input  logic   code_ready,
	input  code_t  code_item,
	input  logic   instr_valid,
	input  logic   instr_ready,
	input  instr_t instr_item,
	output int     fail_count,
	output int     pending,
	output int     instrs_checked,
	output int     bad_mode_count,
	output int     bad_op_count
);

	localparam int MAX_REPORTS = 40;

	// Operand count per opcode, two bits each, opcode 0 in the low bits
	localparam logic [51:0] OPERANDS_PER_OPCODE = {
		2'd0, 2'd0,
		2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd1,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd1, 2'd2,
		2'd0, 2'd0
	};

	typedef enum logic [1:0] {AWAIT_OPCODE, AWAIT_DESC, AWAIT_EXT1, AWAIT_EXT2} phase_t;

	// Decoder state as seen from the byte stream
	phase_t     ph;
	logic [4:0] held_opcode;
	logic       held_byte_ops;
	logic [2:0] byte_count;
	logic       op_idx;
	logic [1:0] ops_needed;
	logic [2:0] cur_mode;
	logic [3:0] cur_reg;
	logic [7:0] low_byte;
	oper_t      first_op;

	instr_t pending_instrs[$];
	instr_t predicted;
	instr_t oldest;
	logic   produced;

	function automatic oper_t operand(input logic [2:0] m, input logic [15:0] v,
			input logic [15:0] x);
		oper_t o;
		o.mode  = m;
		o.value = v;
		o.extra = x;
		return o;
	endfunction

	// Assemble a decoded instruction from the held state
	function automatic instr_t pack_instr(input logic [1:0] count, input oper_t b,
			input logic [1:0] err);
		instr_t r;
		r.opcode   = held_opcode;
		r.byte_ops = held_byte_ops;
		r.length   = byte_count;
		r.op_count = count;
		r.mode_a   = (count != 2'd0) ? first_op.mode  : 3'd0;
		r.value_a  = (count != 2'd0) ? first_op.value : 16'd0;
		r.extra_a  = (count != 2'd0) ? first_op.extra : 16'd0;
		r.mode_b   = b.mode;
		r.value_b  = b.value;
		r.extra_b  = b.extra;
		r.error    = err;
		return r;
	endfunction

	// Close the current operand; emit when the last one is done
	task automatic end_operand(input oper_t o, output logic done, output instr_t r);
		done = 1'b0;
		r    = '0;
		if (!op_idx) begin
			first_op = o;
			if (ops_needed >= 2'd2) begin
				op_idx = 1'b1;
				ph     = AWAIT_DESC;
			end else begin
				r    = pack_instr(2'd1, '0, ERR_NONE);
				done = 1'b1;
				ph   = AWAIT_OPCODE;
			end
		end else begin
			r    = pack_instr(2'd2, o, ERR_NONE);
			done = 1'b1;
			ph   = AWAIT_OPCODE;
		end
	endtask

	// Advance the decode by one code byte
	task automatic decode_byte(input code_t c, output logic done, output instr_t r);
		logic [7:0]  b;
		logic [15:0] word;
		b    = c.code_byte;
		done = 1'b0;
		r    = '0;
		if (c.restart || ph == AWAIT_OPCODE) begin
			held_opcode   = 5'(b >> OPCODE_SHIFT);
			held_byte_ops = ~b[SIZE_BIT_POS];
			byte_count    = 3'd1;
			op_idx        = 1'b0;
			first_op      = '0;
			ops_needed    = (held_opcode < TABLE_LEN) ?
				OPERANDS_PER_OPCODE[held_opcode * 2 +: 2] : 2'd0;
			if (held_opcode >= TABLE_LEN || ops_needed == 2'd0) begin
				r    = pack_instr(2'd0, '0,
					(held_opcode >= TABLE_LEN) ? ERR_BAD_OP : ERR_NONE);
				done = 1'b1;
				ph   = AWAIT_OPCODE;
			end else begin
				ph = AWAIT_DESC;
			end
		end else begin
			byte_count = byte_count + 3'd1;
			case (ph)
				AWAIT_DESC: begin
					cur_mode = 3'(b >> MODE_SHIFT);
					cur_reg  = 4'(b >> REG_SHIFT);
					case (cur_mode)
						MODE_IMMED, MODE_REGIND8, MODE_REGIND16, MODE_MEMORY: begin
							ph = AWAIT_EXT1;
						end
						MODE_REGDIR: begin
							end_operand(operand(MODE_REGDIR, 16'(cur_reg), 16'(b[0])),
								done, r);
						end
						MODE_REGIND: begin
							end_operand(operand(MODE_REGIND, 16'(cur_reg), 16'd0), done, r);
						end
						default: begin
							r    = pack_instr(2'(op_idx), '0, ERR_BAD_MODE);
							done = 1'b1;
							ph   = AWAIT_OPCODE;
						end
					endcase
				end
				AWAIT_EXT1: begin
					if (cur_mode == MODE_REGIND8) begin
						end_operand(operand(MODE_REGIND8, 16'(cur_reg), 16'(b)), done, r);
					end else if (cur_mode == MODE_IMMED && held_byte_ops) begin
						end_operand(operand(MODE_IMMED, 16'(b), 16'd0), done, r);
					end else begin
						low_byte = b;
						ph       = AWAIT_EXT2;
					end
				end
				default: begin
					word = {b, low_byte};
					if (cur_mode == MODE_REGIND16) begin
						end_operand(operand(MODE_REGIND16, 16'(cur_reg), word), done, r);
					end else if (cur_mode == MODE_MEMORY) begin
						end_operand(operand(MODE_MEMORY, word, 16'd0), done, r);
					end else begin
						end_operand(operand(MODE_IMMED, word, 16'd0), done, r);
					end
				end
			endcase
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			if (fail_count < MAX_REPORTS) begin
				$display("%0t: instr %0d %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, instrs_checked, name, want, got);
			end
			fail_count++;
		end
	endtask

	// Compare outgoing transactions first, then predict from the incoming one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph             = AWAIT_OPCODE;
			held_opcode    = '0;
			held_byte_ops  = 1'b0;
			byte_count     = '0;
			op_idx         = 1'b0;
			ops_needed     = '0;
			cur_mode       = '0;
			cur_reg        = '0;
			low_byte       = '0;
			first_op       = '0;
			pending_instrs.delete();
			fail_count     = 0;
			instrs_checked = 0;
			bad_mode_count = 0;
			bad_op_count   = 0;
		end else begin
			if (instr_valid && instr_ready) begin
				if (pending_instrs.size() == 0) begin
					if (fail_count < MAX_REPORTS) begin
						$display("%0t: unexpected instr, expected none, actual 0x%h",
							$time, instr_item);
					end
					fail_count++;
				end else begin
					oldest = pending_instrs.pop_front();
					check_field("opcode",   oldest.opcode,   instr_item.opcode);
					check_field("byte_ops", oldest.byte_ops, instr_item.byte_ops);
					check_field("length",   oldest.length,   instr_item.length);
					check_field("op_count", oldest.op_count, instr_item.op_count);
					check_field("mode_a",   oldest.mode_a,   instr_item.mode_a);
					check_field("value_a",  oldest.value_a,  instr_item.value_a);
					check_field("extra_a",  oldest.extra_a,  instr_item.extra_a);
					check_field("mode_b",   oldest.mode_b,   instr_item.mode_b);
					check_field("value_b",  oldest.value_b,  instr_item.value_b);
					check_field("extra_b",  oldest.extra_b,  instr_item.extra_b);
					check_field("error",    oldest.error,    instr_item.error);
					if (oldest.error == ERR_BAD_MODE) bad_mode_count++;
					if (oldest.error == ERR_BAD_OP) bad_op_count++;
					instrs_checked++;
				end
			end
			if (code_valid && code_ready) begin
				decode_byte(code_item, produced, predicted);
				if (produced) pending_instrs.push_back(predicted);
			end
		end
		pending = pending_instrs.size();
	end

endmodule

@@ tb/sv/tb_variable_length_instruction_decoder.sv @@
`timescale 1ns / 1ps
module tb_variable_length_instruction_decoder;
	import vlid_pkg::*;

	localparam int NUM_RANDOM_BYTES = 700;
	localparam int DRAIN_LIMIT      = 5000;

	// Operand count per opcode for building well-formed instructions
	localparam logic [51:0] OPS_BY_OPCODE = {
		2'd0, 2'd0,
		2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd1,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd1, 2'd2,
		2'd0, 2'd0
	};

	logic   clk;
	logic   arst_n      = 1'b0;
	logic   code_valid  = 1'b0;
	logic   code_ready;
	code_t  code_item   = '0;
	logic   instr_valid;
	logic   instr_ready = 1'b0;
	instr_t instr_item;

	int fail_count;
	int pending;
	int instrs_checked;
	int bad_mode_count;
	int bad_op_count;

	code_t       code_stream[$];
	int unsigned restart_bytes = 0;

	variable_length_instruction_decoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.code_valid  (code_valid),
		.code_ready  (code_ready),
		.code_item   (code_item),
		.instr_valid (instr_valid),
		.instr_ready (instr_ready),
		.instr_item  (instr_item)
	);

	vlid_decode_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.code_valid     (code_valid),
		.code_ready     (code_ready),
		.code_item      (code_item),
		.instr_valid    (instr_valid),
		.instr_ready    (instr_ready),
		.instr_item     (instr_item),
		.fail_count     (fail_count),
		.pending        (pending),
		.instrs_checked (instrs_checked),
		.bad_mode_count (bad_mode_count),
		.bad_op_count   (bad_op_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d instructions still expected", pending);
		$display("FAILURE");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b, input logic rs);
		code_t c;
		c.code_byte = b;
		c.restart   = rs;
		code_stream.push_back(c);
		if (rs) restart_bytes++;
	endtask

	// Build one instruction with random content; optionally cut it short
	task automatic add_instr(input logic [4:0] opc, input logic rs, input bit cut);
		logic [7:0]  seq[$];
		logic        byte_size;
		logic [2:0]  m;
		int          n_ops;
		int          n_ext;
		int          keep;
		seq.push_back({opc, 3'($urandom_range(0, 7))});
		byte_size = ~seq[0][SIZE_BIT_POS];
		n_ops = (opc < TABLE_LEN) ? int'(OPS_BY_OPCODE[opc * 2 +: 2]) : 0;
		for (int i = 0; i < n_ops; i++) begin
			m = ($urandom_range(0, 99) < 5) ? 3'($urandom_range(6, 7)) :
				3'($urandom_range(0, 5));
			seq.push_back({m, 5'($urandom_range(0, 31))});
			if (m > MODE_MEMORY) break;
			case (m)
				MODE_IMMED:                 n_ext = byte_size ? 1 : 2;
				MODE_REGIND8:               n_ext = 1;
				MODE_REGIND16, MODE_MEMORY: n_ext = 2;
				default:                    n_ext = 0;
			endcase
			repeat (n_ext) seq.push_back(8'($urandom_range(0, 255)));
		end
		keep = (cut && seq.size() > 1) ? $urandom_range(1, seq.size() - 1) : seq.size();
		for (int i = 0; i < keep; i++) push_byte(seq[i], (i == 0) ? rs : 1'b0);
	endtask

	// Offer one transaction and hold it until accepted
	task automatic send_byte(input code_t c);
		code_valid <= 1'b1;
		code_item  <= c;
		do @(posedge clk); while (!code_ready);
	endtask

	// Receiver: acceptance rate rotates, with two long hold-offs
	initial begin
		int unsigned cyc;
		int unsigned duty;
		int unsigned sel;
		cyc  = 0;
		duty = 100;
		sel  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 128 == 0) begin
				sel = (sel + 1) % 5;
				case (sel)
					0:       duty = 100;
					1:       duty = 60;
					2:       duty = 25;
					3:       duty = 90;
					default: duty = 8;
				endcase
			end
			if ((cyc >= 300 && cyc < 380) || (cyc >= 1500 && cyc < 1560)) begin
				instr_ready <= 1'b0;
			end else begin
				instr_ready <= ($urandom_range(1, 100) <= duty);
			end
		end
	end

	initial begin
		int unsigned directed_count;
		int unsigned total_bytes;
		int unsigned pick;
		int unsigned burst;
		int unsigned gap;
		int unsigned waited;
		logic        next_rs;

		// Zero-operand opcodes at both table ends, byte and word size
		push_byte(8'h00, 1'b0);
		push_byte(8'hCC, 1'b0);
		// Opcode beyond table, all bits set
		push_byte(8'hFF, 1'b0);
		// Two operands, word: immediate 0xFFFF, memory address 0x1234
		push_byte(8'h14, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hA0, 1'b0);
		push_byte(8'h34, 1'b0);
		push_byte(8'h12, 1'b0);
		// One operand, byte: regind8 register 15, displacement 0xFF
		push_byte(8'h18, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'hFF, 1'b0);
		// Two operands, byte: regdir high select, byte immediate
		push_byte(8'h20, 1'b0);
		push_byte(8'h3F, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hAB, 1'b0);
		// One operand, word: regind16 displacement 0xABCD
		push_byte(8'h8C, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hCD, 1'b0);
		push_byte(8'hAB, 1'b0);
		// Unknown addressing mode on the first operand
		push_byte(8'h50, 1'b0);
		push_byte(8'hC0, 1'b0);
		// Unknown addressing mode on the second operand, after regind
		push_byte(8'h58, 1'b0);
		push_byte(8'h5E, 1'b0);
		push_byte(8'hFF, 1'b0);
		// Restart in the middle of an instruction drops it
		push_byte(8'h10, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h08, 1'b1);
		directed_count = code_stream.size();

		// Mostly well-formed instructions, some cut short, bad opcodes and noise
		next_rs = 1'b0;
		while (code_stream.size() < directed_count + NUM_RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				add_instr(5'($urandom_range(0, 25)), next_rs | ($urandom_range(0, 9) == 0),
					1'b0);
				next_rs = 1'b0;
			end else if (pick < 86) begin
				add_instr(5'($urandom_range(26, 31)), next_rs | ($urandom_range(0, 1) == 0),
					1'b0);
				next_rs = 1'b0;
			end else if (pick < 94) begin
				add_instr(5'($urandom_range(0, 25)), next_rs, 1'b1);
				next_rs = 1'b1;
			end else begin
				push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				next_rs = 1'b1;
			end
		end
		total_bytes = code_stream.size();

		// Hold reset, then release it
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Send in bursts; a zero gap merges bursts into an unbroken stretch
		while (code_stream.size() != 0) begin
			burst = $urandom_range(1, 24);
			while (burst != 0 && code_stream.size() != 0) begin
				send_byte(code_stream.pop_front());
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				code_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		code_valid <= 1'b0;

		// Drain outstanding instructions, then allow for the pipeline latency
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);

		$display("Drove %0d code bytes (%0d with restart) in random bursts and gaps,",
			total_bytes, restart_bytes);
		$display("checked %0d instructions: %0d bad mode, %0d bad opcode, %0d left over",
			instrs_checked, bad_mode_count, bad_op_count, pending);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ variable_length_instruction_decoder.f @@
rtl/vlid_pkg.sv
rtl/vlid_front.sv
rtl/vlid_queue.sv
rtl/vlid_back.sv
rtl/variable_length_instruction_decoder.sv
tb/sv/vlid_decode_checker.sv
tb/sv/tb_variable_length_instruction_decoder.sv
